// ===== hdl/gsplit_pkg.sv =====
// ----------------------------------------------------------------------------
// Greedy route splitter package
// Shared result kinds, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gsplit_pkg;

   localparam int ID_BITS     = 16;
   localparam int LOAD_BITS   = 16;
   localparam int COUNT_BITS  = 16;
   localparam int LEN_BITS    = 25;
   localparam int SUM_BITS    = 40;
   localparam int KIND_BITS   = 2;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [CSR_IDX_BITS-1:0] REG_DEPOT_X    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DEPOT_Y    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_CAPACITY   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_CLOSE_TIME = 2'd3;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ASSIGNED   = 2'd0,
      KIND_CLOSED     = 2'd1,
      KIND_INFEASIBLE = 2'd2,
      KIND_TOTALS     = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      DS_ORIGIN  = 2'd0,
      DS_BACK    = 2'd1,
      DS_CURRENT = 2'd2
   } dist_sel_type;

   typedef struct packed {
      logic         load_req;
      logic         dist_start;
      dist_sel_type dsel;
      logic         commit;
      logic         eval_back;
      logic         close;
      logic         close_back;
      logic         err_emit;
      logic         totals;
   } cmd_type;

   typedef struct packed {
      logic fit;
      logic error;
      logic members_zero;
      logic is_last;
      logic out_free;
      logic dist_done;
   } status_type;

endpackage

// ===== hdl/greedy_route_splitter_time_windows.sv =====
// ----------------------------------------------------------------------------
// Greedy route splitter with time windows
// Appends each customer request to the open vehicle route, starts a new one, or reports it infeasible.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each distance comes from a shared
// square-root unit; a request needs two distances, and a third when the
// open route is closed and the customer is retried from the depot. A
// request that arrives after an infeasible customer needs no distance. The
// last request of a set adds a totals step, the route close being issued
// in a state that every request passes through anyway.
// Results are held in an output register, so a stalled response channel holds
// the block only when a further result is ready to be written.
module greedy_route_splitter_time_windows #(
   parameter int COORD_BITS = 12,
   parameter int TIME_BITS  = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [gsplit_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [((TIME_BITS > 16) ? TIME_BITS : 16)-1:0] csr_data,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [gsplit_pkg::ID_BITS-1:0]             req_customer_id,
   input  logic [COORD_BITS-1:0]                      req_pos_x,
   input  logic [COORD_BITS-1:0]                      req_pos_y,
   input  logic [gsplit_pkg::LOAD_BITS-1:0]           req_demand,
   input  logic [TIME_BITS-1:0]                       req_ready_time,
   input  logic [TIME_BITS-1:0]                       req_due_time,
   input  logic [TIME_BITS-1:0]                       req_service_time,
   input  logic                                       req_is_last,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [gsplit_pkg::KIND_BITS-1:0]           rsp_kind,
   output logic [gsplit_pkg::ID_BITS-1:0]             rsp_out_customer,
   output logic [gsplit_pkg::COUNT_BITS-1:0]          rsp_route_index,
   output logic [gsplit_pkg::LEN_BITS-1:0]            rsp_route_length,
   output logic [gsplit_pkg::COUNT_BITS-1:0]          rsp_total_routes,
   output logic [gsplit_pkg::SUM_BITS-1:0]            rsp_total_length,
   output logic                                       rsp_last_result
);
   import gsplit_pkg::*;

   cmd_type    cmd;
   status_type status;

   gsplit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gsplit_dp #(
      .COORD_BITS (COORD_BITS),
      .TIME_BITS  (TIME_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_customer_id  (req_customer_id),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_demand       (req_demand),
      .req_ready_time   (req_ready_time),
      .req_due_time     (req_due_time),
      .req_service_time (req_service_time),
      .req_is_last      (req_is_last),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_out_customer (rsp_out_customer),
      .rsp_route_index  (rsp_route_index),
      .rsp_route_length (rsp_route_length),
      .rsp_total_routes (rsp_total_routes),
      .rsp_total_length (rsp_total_length),
      .rsp_last_result  (rsp_last_result)
   );

endmodule

// ===== hdl/gsplit_dist.sv =====
// ----------------------------------------------------------------------------
// Distance unit
// Squares the coordinate differences, then extracts a fixed-point square root
// one digit per cycle.
// ----------------------------------------------------------------------------
module gsplit_dist #(
   parameter int COORD_BITS = 12,
   parameter int FRAC_BITS  = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [COORD_BITS-1:0]           ax,
   input  logic [COORD_BITS-1:0]           ay,
   input  logic [COORD_BITS-1:0]           bx,
   input  logic [COORD_BITS-1:0]           by,
   output logic                            done,
   output logic [COORD_BITS+FRAC_BITS:0]   leg_len
);
   localparam int RW = COORD_BITS + 1 + FRAC_BITS;
   localparam int CW = $clog2(RW + 1);
   localparam int SW = 2 * COORD_BITS + 1;

   logic [COORD_BITS-1:0] dx_in, dy_in, dx_ff, dy_ff;
   logic                  sq_ff, busy_ff, done_ff;
   logic [CW-1:0]         cnt_ff;
   logic [2*RW-1:0]       rad_ff;
   logic [RW+1:0]         rem_ff, rem_w, trial;
   logic [RW-1:0]         root_ff;
   logic [SW-1:0]         sum_sq;
   logic                  ge;

   always_comb begin
      dx_in  = (ax >= bx) ? (ax - bx) : (bx - ax);
      dy_in  = (ay >= by) ? (ay - by) : (by - ay);
      sum_sq = SW'(dx_ff) * SW'(dx_ff) + SW'(dy_ff) * SW'(dy_ff);
      rem_w  = {rem_ff[RW-1:0], rad_ff[2*RW-1 -: 2]};
      trial  = {root_ff, 2'b01};
      ge     = (rem_w >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff   <= 1'b0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dx_ff <= dx_in;
            dy_ff <= dy_in;
            sq_ff <= 1'b1;
         end else if (sq_ff) begin
            sq_ff   <= 1'b0;
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(RW);
            rad_ff  <= (2*RW)'(sum_sq) << (2 * FRAC_BITS);
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            rad_ff  <= rad_ff << 2;
            rem_ff  <= ge ? (rem_w - trial) : rem_w;
            root_ff <= {root_ff[RW-2:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign leg_len = root_ff;

endmodule

// ===== hdl/gsplit_dp.sv =====
// ----------------------------------------------------------------------------
// Route splitter datapath
// Holds registers, route state, distances, feasibility test and result register.
// ----------------------------------------------------------------------------
module gsplit_dp #(
   parameter int COORD_BITS = 12,
   parameter int TIME_BITS  = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [gsplit_pkg::CSR_IDX_BITS-1:0]        csr_index,
   input  logic [((TIME_BITS > 16) ? TIME_BITS : 16)-1:0] csr_data,
   input  logic [gsplit_pkg::ID_BITS-1:0]             req_customer_id,
   input  logic [COORD_BITS-1:0]                      req_pos_x,
   input  logic [COORD_BITS-1:0]                      req_pos_y,
   input  logic [gsplit_pkg::LOAD_BITS-1:0]           req_demand,
   input  logic [TIME_BITS-1:0]                       req_ready_time,
   input  logic [TIME_BITS-1:0]                       req_due_time,
   input  logic [TIME_BITS-1:0]                       req_service_time,
   input  logic                                       req_is_last,
   input  gsplit_pkg::cmd_type                        cmd,
   output gsplit_pkg::status_type                     status,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic [gsplit_pkg::KIND_BITS-1:0]           rsp_kind,
   output logic [gsplit_pkg::ID_BITS-1:0]             rsp_out_customer,
   output logic [gsplit_pkg::COUNT_BITS-1:0]          rsp_route_index,
   output logic [gsplit_pkg::LEN_BITS-1:0]            rsp_route_length,
   output logic [gsplit_pkg::COUNT_BITS-1:0]          rsp_total_routes,
   output logic [gsplit_pkg::SUM_BITS-1:0]            rsp_total_length,
   output logic                                       rsp_last_result
);
   import gsplit_pkg::*;

   localparam int RW = COORD_BITS + 1 + FRAC_BITS;
   localparam int TF = TIME_BITS + FRAC_BITS;
   localparam int M  = (TF + 1 > RW) ? TF + 1 : RW;
   localparam int WT = M + 2;
   localparam int LW = (WT > LEN_BITS + 1) ? WT : LEN_BITS + 1;

   logic [ID_BITS-1:0]    id_ff;
   logic [COORD_BITS-1:0] px_ff, py_ff, depx_ff, depy_ff, curx_ff, cury_ff;
   logic [LOAD_BITS-1:0]  demand_ff, cap_ff;
   logic [TIME_BITS-1:0]  ready_ff, due_ff, serv_ff, close_ff;
   logic                  last_ff, err_ff;
   logic [WT-1:0]         rtime_ff;
   logic [LOAD_BITS:0]    load_ff;
   logic [COUNT_BITS-1:0] members_ff, routes_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [RW-1:0]         da_ff, db_ff, dc_ff, leg_len;
   dist_sel_type          dsel_ff;
   logic                  dist_done;

   logic                  valid_ff, last_res_ff;
   kind_type              kind_ff;
   logic [ID_BITS-1:0]    ocust_ff;
   logic [COUNT_BITS-1:0] ridx_ff, troutes_ff;
   logic [LEN_BITS-1:0]   rlen_ff;
   logic [SUM_BITS-1:0]   tlen_ff;

   logic [COORD_BITS-1:0] ax, ay, bx, by;
   logic [WT-1:0]         d_sel, st_raw, ready_s, st, due_s, serv_s, close_s, newt;
   logic [LOAD_BITS:0]    load_new;
   logic                  fit;
   logic [LW-1:0]         len_ext;
   logic [LEN_BITS-1:0]   len25;
   logic [SUM_BITS:0]     sum_ext;
   logic [SUM_BITS-1:0]   sum_new;
   logic                  mem_zero;

   gsplit_dist #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dist (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.dist_start),
      .ax      (ax),
      .ay      (ay),
      .bx      (bx),
      .by      (by),
      .done    (dist_done),
      .leg_len (leg_len)
   );

   always_comb begin
      mem_zero = (members_ff == '0);
      unique case (cmd.dsel)
         DS_ORIGIN: begin
            ax = mem_zero ? depx_ff : curx_ff;
            ay = mem_zero ? depy_ff : cury_ff;
            bx = px_ff;
            by = py_ff;
         end
         DS_BACK: begin
            ax = px_ff;
            ay = py_ff;
            bx = depx_ff;
            by = depy_ff;
         end
         default: begin
            ax = curx_ff;
            ay = cury_ff;
            bx = depx_ff;
            by = depy_ff;
         end
      endcase

      d_sel    = cmd.eval_back ? WT'(db_ff) : WT'(da_ff);
      st_raw   = rtime_ff + d_sel;
      ready_s  = WT'({ready_ff, {FRAC_BITS{1'b0}}});
      due_s    = WT'({due_ff, {FRAC_BITS{1'b0}}});
      serv_s   = WT'({serv_ff, {FRAC_BITS{1'b0}}});
      close_s  = WT'({close_ff, {FRAC_BITS{1'b0}}});
      st       = (st_raw < ready_s) ? ready_s : st_raw;
      newt     = st + serv_s;
      load_new = load_ff + (LOAD_BITS+1)'(demand_ff);
      fit      = (st < due_s) && (load_new <= (LOAD_BITS+1)'(cap_ff))
                 && ((newt + WT'(db_ff)) < close_s);

      len_ext  = LW'(rtime_ff) + LW'(cmd.close_back ? db_ff : dc_ff);
      len25    = (len_ext > LW'({LEN_BITS{1'b1}})) ? {LEN_BITS{1'b1}}
                                                   : len_ext[LEN_BITS-1:0];
      sum_ext  = {1'b0, sum_ff} + (SUM_BITS+1)'(len25);
      sum_new  = sum_ext[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_ext[SUM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depx_ff    <= '0;
         depy_ff    <= '0;
         cap_ff     <= '0;
         close_ff   <= '0;
         curx_ff    <= '0;
         cury_ff    <= '0;
         rtime_ff   <= '0;
         load_ff    <= '0;
         members_ff <= '0;
         routes_ff  <= '0;
         sum_ff     <= '0;
         err_ff     <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_DEPOT_X:    depx_ff  <= csr_data[COORD_BITS-1:0];
               REG_DEPOT_Y:    depy_ff  <= csr_data[COORD_BITS-1:0];
               REG_CAPACITY:   cap_ff   <= csr_data[LOAD_BITS-1:0];
               REG_CLOSE_TIME: close_ff <= csr_data[TIME_BITS-1:0];
               default: ;
            endcase
         end

         if (cmd.load_req) begin
            id_ff     <= req_customer_id;
            px_ff     <= req_pos_x;
            py_ff     <= req_pos_y;
            demand_ff <= req_demand;
            ready_ff  <= req_ready_time;
            due_ff    <= req_due_time;
            serv_ff   <= req_service_time;
            last_ff   <= req_is_last;
         end

         if (cmd.dist_start) begin
            dsel_ff <= cmd.dsel;
         end
         if (dist_done) begin
            unique case (dsel_ff)
               DS_ORIGIN: da_ff <= leg_len;
               DS_BACK:   db_ff <= leg_len;
               default:   dc_ff <= leg_len;
            endcase
         end

         if (rsp_ready) begin
            valid_ff <= 1'b0;
         end

         if (cmd.commit) begin
            valid_ff    <= 1'b1;
            ocust_ff    <= id_ff;
            ridx_ff     <= routes_ff;
            rlen_ff     <= '0;
            troutes_ff  <= '0;
            tlen_ff     <= '0;
            last_res_ff <= !last_ff;
            if (fit) begin
               kind_ff  <= KIND_ASSIGNED;
               rtime_ff <= newt;
               load_ff  <= load_new;
               curx_ff  <= px_ff;
               cury_ff  <= py_ff;
               if (members_ff != {COUNT_BITS{1'b1}}) begin
                  members_ff <= members_ff + 1'b1;
               end
            end else begin
               kind_ff <= KIND_INFEASIBLE;
               err_ff  <= 1'b1;
            end
         end

         if (cmd.err_emit) begin
            valid_ff    <= 1'b1;
            kind_ff     <= KIND_INFEASIBLE;
            ocust_ff    <= id_ff;
            ridx_ff     <= routes_ff;
            rlen_ff     <= '0;
            troutes_ff  <= '0;
            tlen_ff     <= '0;
            last_res_ff <= !last_ff;
         end

         if (cmd.close) begin
            valid_ff    <= 1'b1;
            kind_ff     <= KIND_CLOSED;
            ocust_ff    <= '0;
            ridx_ff     <= routes_ff;
            rlen_ff     <= len25;
            troutes_ff  <= '0;
            tlen_ff     <= '0;
            last_res_ff <= 1'b0;
            if (routes_ff != {COUNT_BITS{1'b1}}) begin
               routes_ff <= routes_ff + 1'b1;
            end
            sum_ff     <= sum_new;
            rtime_ff   <= '0;
            load_ff    <= '0;
            members_ff <= '0;
            curx_ff    <= depx_ff;
            cury_ff    <= depy_ff;
         end

         if (cmd.totals) begin
            valid_ff    <= 1'b1;
            kind_ff     <= KIND_TOTALS;
            ocust_ff    <= '0;
            ridx_ff     <= '0;
            rlen_ff     <= '0;
            troutes_ff  <= err_ff ? {COUNT_BITS{1'b1}} : routes_ff;
            tlen_ff     <= sum_ff;
            last_res_ff <= 1'b1;
            curx_ff     <= depx_ff;
            cury_ff     <= depy_ff;
            rtime_ff    <= '0;
            load_ff     <= '0;
            members_ff  <= '0;
            routes_ff   <= '0;
            sum_ff      <= '0;
            err_ff      <= 1'b0;
         end
      end
   end

   assign csr_ready = 1'b1;

   assign status.fit          = fit;
   assign status.error        = err_ff;
   assign status.members_zero = mem_zero;
   assign status.is_last      = last_ff;
   assign status.out_free     = !valid_ff || rsp_ready;
   assign status.dist_done    = dist_done;

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_out_customer = ocust_ff;
   assign rsp_route_index  = ridx_ff;
   assign rsp_route_length = rlen_ff;
   assign rsp_total_routes = troutes_ff;
   assign rsp_total_length = tlen_ff;
   assign rsp_last_result  = last_res_ff;

endmodule

// ===== hdl/gsplit_ctrl.sv =====
// ----------------------------------------------------------------------------
// Route splitter controller
// Sequences distance computations, the feasibility decision and the results.
// ----------------------------------------------------------------------------
module gsplit_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gsplit_pkg::status_type status,
   output gsplit_pkg::cmd_type    cmd
);
   import gsplit_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_WAIT_A, S_WAIT_B, S_EVAL, S_WAIT_C,
      S_CLOSE, S_RETRY, S_ERR, S_LAST, S_TOTAL
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.dsel  = DS_ORIGIN;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (status.error) begin
               state_in = S_ERR;
            end else begin
               cmd.dist_start = 1'b1;
               cmd.dsel       = DS_ORIGIN;
               state_in       = S_WAIT_A;
            end
         end
         S_WAIT_A: begin
            if (status.dist_done) begin
               cmd.dist_start = 1'b1;
               cmd.dsel       = DS_BACK;
               state_in       = S_WAIT_B;
            end
         end
         S_WAIT_B: begin
            if (status.dist_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (status.fit || status.members_zero) begin
               if (status.out_free) begin
                  cmd.commit = 1'b1;
                  state_in   = S_LAST;
               end
            end else begin
               cmd.dist_start = 1'b1;
               cmd.dsel       = DS_CURRENT;
               state_in       = S_WAIT_C;
            end
         end
         S_WAIT_C: begin
            if (status.dist_done) begin
               state_in = S_CLOSE;
            end
         end
         S_CLOSE: begin
            if (status.out_free) begin
               cmd.close = 1'b1;
               state_in  = S_RETRY;
            end
         end
         S_RETRY: begin
            if (status.out_free) begin
               cmd.commit    = 1'b1;
               cmd.eval_back = 1'b1;
               state_in      = S_LAST;
            end
         end
         S_ERR: begin
            if (status.out_free) begin
               cmd.err_emit = 1'b1;
               state_in     = S_LAST;
            end
         end
         S_LAST: begin
            if (!status.is_last) begin
               state_in = S_IDLE;
            end else if (!status.error && !status.members_zero) begin
               if (status.out_free) begin
                  cmd.close      = 1'b1;
                  cmd.close_back = 1'b1;
                  state_in       = S_TOTAL;
               end
            end else begin
               state_in = S_TOTAL;
            end
         end
         S_TOTAL: begin
            if (status.out_free) begin
               cmd.totals = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
